FILE: design/utcv_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package utcv_pkg;

  typedef enum logic [1:0] {
    ZS_NONE  = 2'd0,
    ZS_UTC   = 2'd1,
    ZS_PLUS  = 2'd2,
    ZS_MINUS = 2'd3
  } zsign_t;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UTC   = 8'h5A;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;

  localparam logic [4:0] POS_SHORT = 5'd10;
  localparam logic [4:0] POS_FULL  = 5'd12;
  localparam logic [4:0] POS_LIMIT = 5'd17;
  localparam logic [4:0] POS_SAT   = 5'd31;
  localparam logic [4:0] OFS_CHARS = 5'd4;

  localparam logic [2:0] IDX_YEAR   = 3'd0;
  localparam logic [2:0] IDX_MONTH  = 3'd1;
  localparam logic [2:0] IDX_DAY    = 3'd2;
  localparam logic [2:0] IDX_HOUR   = 3'd3;
  localparam logic [2:0] IDX_MINUTE = 3'd4;
  localparam logic [2:0] IDX_SECOND = 3'd5;
  localparam logic [2:0] IDX_OFS_HR = 3'd6;
  localparam logic [2:0] IDX_OFS_MI = 3'd7;

  localparam logic [6:0]  YEAR_PIVOT    = 7'd50;
  localparam logic [11:0] CENTURY_19    = 12'd1900;
  localparam logic [11:0] CENTURY_20    = 12'd2000;
  localparam logic [6:0]  HOURS_PER_DAY = 7'd24;
  localparam logic [6:0]  MINS_PER_HOUR = 7'd60;

  typedef struct packed {
    logic             err;
    zsign_t           zsign;
    logic [4:0]       zpos;
    logic [5:0]       len;
    logic [7:0][6:0]  digits;
  } rec_t;

  function automatic logic [6:0] add_digit(input logic [6:0] f, input logic [3:0] d);
    logic [10:0] acc;
    acc = {4'd0, f} * 11'd10 + {7'd0, d};
    return acc[6:0];
  endfunction

  // Years seen here span 1950..2049, so the century rule only touches 2000 (a leap year)
  function automatic logic [4:0] month_len(input logic [6:0] mon, input logic leap);
    logic [4:0] n;
    unique case (mon) inside
      7'd1, 7'd3, 7'd5, 7'd7, 7'd8, 7'd10, 7'd12: n = 5'd31;
      7'd4, 7'd6, 7'd9, 7'd11:                   n = 5'd30;
      7'd2:                                      n = leap ? 5'd29 : 5'd28;
      default:                                   n = 5'd0;
    endcase
    return n;
  endfunction

endpackage

`default_nettype wire

FILE: design/utcv_front.sv
`timescale 1ns / 1ps
`default_nettype none

module utcv_front
  import utcv_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_char_byte,
  input  wire logic       in_last_char,
  input  wire logic       q_full,
  output logic            push,
  output rec_t            push_rec
);

  logic [4:0]      pos_r, pos_nxt;
  logic [7:0][6:0] dig_r, dig_nxt;
  logic [4:0]      zpos_r, zpos_nxt;
  zsign_t          zsign_r, zsign_nxt;
  logic            err_r, err_nxt;
  logic            accept, digit, marker;
  logic [4:0]      q;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign push     = accept && in_last_char;
  assign digit    = (in_char_byte >= CH_ZERO) && (in_char_byte <= CH_NINE);
  assign marker   = (in_char_byte == CH_UTC) || (in_char_byte == CH_PLUS) ||
                    (in_char_byte == CH_MINUS);
  assign q        = pos_r - zpos_r - 5'd1;

  always_comb begin
    pos_nxt   = (pos_r < POS_SAT) ? pos_r + 5'd1 : pos_r;
    dig_nxt   = dig_r;
    zpos_nxt  = zpos_r;
    zsign_nxt = zsign_r;
    err_nxt   = err_r;
    if (pos_r >= POS_LIMIT) begin
      err_nxt = 1'b1;
    end else if (zsign_r == ZS_NONE) begin
      if (marker) begin
        zpos_nxt = pos_r;
        if (in_char_byte == CH_UTC) begin
          zsign_nxt = ZS_UTC;
        end else if (in_char_byte == CH_PLUS) begin
          zsign_nxt = ZS_PLUS;
        end else begin
          zsign_nxt = ZS_MINUS;
        end
        if (pos_r != POS_SHORT && pos_r != POS_FULL) begin
          err_nxt = 1'b1;
        end
      end else if (!digit || pos_r >= POS_FULL) begin
        err_nxt = 1'b1;
      end else begin
        dig_nxt[pos_r[3:1]] = add_digit(dig_r[pos_r[3:1]], in_char_byte[3:0]);
      end
    end else begin
      if (zsign_r == ZS_UTC || q >= OFS_CHARS || !digit) begin
        err_nxt = 1'b1;
      end else begin
        dig_nxt[IDX_OFS_HR + {2'd0, q[1]}] =
          add_digit(dig_r[IDX_OFS_HR + {2'd0, q[1]}], in_char_byte[3:0]);
      end
    end
  end

  always_comb begin
    push_rec.err    = err_nxt;
    push_rec.zsign  = zsign_nxt;
    push_rec.zpos   = zpos_nxt;
    push_rec.len    = {1'b0, pos_r} + 6'd1;
    push_rec.digits = dig_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || push) begin
      pos_r   <= '0;
      dig_r   <= '0;
      zpos_r  <= '0;
      zsign_r <= ZS_NONE;
      err_r   <= 1'b0;
    end else if (accept) begin
      pos_r   <= pos_nxt;
      dig_r   <= dig_nxt;
      zpos_r  <= zpos_nxt;
      zsign_r <= zsign_nxt;
      err_r   <= err_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: design/utcv_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module utcv_queue
  import utcv_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire rec_t push_rec,
  output logic      full,
  input  wire logic pop,
  output logic      empty,
  output rec_t      head
);

  rec_t       mem_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] count_r, count_nxt;

  assign full  = (count_r == 2'd2);
  assign empty = (count_r == 2'd0);
  assign head  = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (pop && !push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      count_r <= count_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: design/utcv_back.sv
`timescale 1ns / 1ps
`default_nettype none

module utcv_back
  import utcv_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         cfg_wr_en,
  input  wire logic         cfg_wr_data,
  input  wire logic         q_empty,
  input  wire rec_t         head,
  output logic              pop,
  output logic              out_valid,
  input  wire logic         out_ready,
  output logic              out_time_valid,
  output logic [11:0]       out_full_year,
  output logic [3:0]        out_month_num,
  output logic [4:0]        out_day_num,
  output logic [4:0]        out_hour_num,
  output logic [5:0]        out_minute_num,
  output logic [5:0]        out_second_num,
  output logic              out_seconds_present,
  output logic              out_non_utc,
  output logic signed [11:0] out_offset_minutes
);

  logic        der_r;
  logic        valid_r;
  logic        ok_r;
  logic [11:0] year_r;
  logic [3:0]  mon_r;
  logic [4:0]  day_r;
  logic [4:0]  hr_r;
  logic [5:0]  mi_r;
  logic [5:0]  se_r;
  logic        secs_r, nonutc_r;
  logic [11:0] off_r;

  logic [6:0]  yy, mon, day, hr, mi, se, tzh, tzm;
  logic [11:0] year;
  logic        secs, nonutc, ok;
  logic [11:0] off_abs;
  logic [11:0] off;

  assign pop = !q_empty && (!valid_r || out_ready);

  always_comb begin
    yy     = head.digits[IDX_YEAR];
    mon    = head.digits[IDX_MONTH];
    day    = head.digits[IDX_DAY];
    hr     = head.digits[IDX_HOUR];
    mi     = head.digits[IDX_MINUTE];
    tzh    = head.digits[IDX_OFS_HR];
    tzm    = head.digits[IDX_OFS_MI];
    secs   = (head.zpos == POS_FULL);
    se     = secs ? head.digits[IDX_SECOND] : 7'd0;
    nonutc = (head.zsign == ZS_PLUS) || (head.zsign == ZS_MINUS);
    year   = ((yy >= YEAR_PIVOT) ? CENTURY_19 : CENTURY_20) + {5'd0, yy};

    ok = !head.err && (head.zsign != ZS_NONE) &&
         (secs || (head.zpos == POS_SHORT && !der_r));
    if (mon < 7'd1 || mon > 7'd12 || day < 7'd1 ||
        day > {2'd0, month_len(mon, yy[1:0] == 2'd0)}) begin
      ok = 1'b0;
    end
    if (hr >= HOURS_PER_DAY || mi >= MINS_PER_HOUR || se >= MINS_PER_HOUR) begin
      ok = 1'b0;
    end
    if (head.zsign == ZS_UTC) begin
      if (head.len != {1'b0, head.zpos} + 6'd1) begin
        ok = 1'b0;
      end
    end else begin
      if (der_r || head.len != {1'b0, head.zpos} + 6'd5 ||
          tzh >= HOURS_PER_DAY || tzm >= MINS_PER_HOUR) begin
        ok = 1'b0;
      end
    end

    off_abs = {5'd0, tzh} * {5'd0, MINS_PER_HOUR} + {5'd0, tzm};
    off     = '0;
    if (nonutc) begin
      off = (head.zsign == ZS_MINUS) ? 12'd0 - off_abs : off_abs;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      der_r   <= 1'b0;
      valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        der_r <= cfg_wr_data;
      end
      if (pop) begin
        valid_r <= 1'b1;
      end else if (out_ready) begin
        valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      ok_r     <= ok;
      year_r   <= ok ? year : 12'd0;
      mon_r    <= ok ? mon[3:0] : 4'd0;
      day_r    <= ok ? day[4:0] : 5'd0;
      hr_r     <= ok ? hr[4:0] : 5'd0;
      mi_r     <= ok ? mi[5:0] : 6'd0;
      se_r     <= ok ? se[5:0] : 6'd0;
      secs_r   <= ok && secs;
      nonutc_r <= ok && nonutc;
      off_r    <= ok ? off : 12'd0;
    end
  end

  assign out_valid           = valid_r;
  assign out_time_valid      = ok_r;
  assign out_full_year       = year_r;
  assign out_month_num       = mon_r;
  assign out_day_num         = day_r;
  assign out_hour_num        = hr_r;
  assign out_minute_num      = mi_r;
  assign out_second_num      = se_r;
  assign out_seconds_present = secs_r;
  assign out_non_utc         = nonutc_r;
  assign out_offset_minutes  = off_r;

endmodule

`default_nettype wire

FILE: design/utctime_string_validator.sv
// UTCTime string checker. Characters arrive one word per cycle on the in_
// channel while in_ready is high (in_char_byte, in_last_char marks the
// end of the string); each string yields one result word on the out_
// channel with the validity flag, decoded date and time fields and the
// zone offset in minutes. Fields of an invalid string read as zero.
// The front parser takes one character per cycle while the queue has room;
// a string's record enters a two-entry queue as its last character is
// accepted; out_valid rises when the checker pops it into its output
// register. Sustained rate with out_ready high is one character per cycle;
// results can leave back to back when strings are one character long.
// When out_ready is low the result holds, the queue fills with up to two
// further records and in_ready then falls until space frees up.
// cfg_wr_en with cfg_wr_data sets DER mode; write it only while idle.
// Synchronous active-low reset empties the queue, clears the parser and
// sets DER mode off.
`timescale 1ns / 1ps
`default_nettype none

module utctime_string_validator
  import utcv_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         cfg_wr_en,
  input  wire logic         cfg_wr_data,
  input  wire logic         in_valid,
  output logic              in_ready,
  input  wire logic [7:0]   in_char_byte,
  input  wire logic         in_last_char,
  output logic              out_valid,
  input  wire logic         out_ready,
  output logic              out_time_valid,
  output logic [11:0]       out_full_year,
  output logic [3:0]        out_month_num,
  output logic [4:0]        out_day_num,
  output logic [4:0]        out_hour_num,
  output logic [5:0]        out_minute_num,
  output logic [5:0]        out_second_num,
  output logic              out_seconds_present,
  output logic              out_non_utc,
  output logic signed [11:0] out_offset_minutes
);

  logic q_full, q_empty, push, pop;
  rec_t push_rec, head;

  utcv_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_char_byte (in_char_byte),
    .in_last_char (in_last_char),
    .q_full       (q_full),
    .push         (push),
    .push_rec     (push_rec)
  );

  utcv_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_rec (push_rec),
    .full     (q_full),
    .pop      (pop),
    .empty    (q_empty),
    .head     (head)
  );

  utcv_back u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_wr_data         (cfg_wr_data),
    .q_empty             (q_empty),
    .head                (head),
    .pop                 (pop),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_time_valid      (out_time_valid),
    .out_full_year       (out_full_year),
    .out_month_num       (out_month_num),
    .out_day_num         (out_day_num),
    .out_hour_num        (out_hour_num),
    .out_minute_num      (out_minute_num),
    .out_second_num      (out_second_num),
    .out_seconds_present (out_seconds_present),
    .out_non_utc         (out_non_utc),
    .out_offset_minutes  (out_offset_minutes)
  );

endmodule

`default_nettype wire

FILE: tb/sv/utctime_result_check.sv
`timescale 1ns / 1ps

module utctime_result_check
  import utcv_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic               cfg_wr_data,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [7:0]         in_char_byte,
  input  logic               in_last_char,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic               out_time_valid,
  input  logic [11:0]        out_full_year,
  input  logic [3:0]         out_month_num,
  input  logic [4:0]         out_day_num,
  input  logic [4:0]         out_hour_num,
  input  logic [5:0]         out_minute_num,
  input  logic [5:0]         out_second_num,
  input  logic               out_seconds_present,
  input  logic               out_non_utc,
  input  logic signed [11:0] out_offset_minutes,
  output int                 fail_count,
  output int                 pending,
  output int                 results_seen,
  output int                 valid_seen
);

  typedef struct packed {
    logic        ok;
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic        secs;
    logic        nonutc;
    logic [11:0] offset;
  } time_fields_t;

  logic         der_on;
  logic [4:0]   char_pos;
  logic [6:0]   pairs [8];
  logic [4:0]   zone_at;
  zsign_t       zone;
  logic         broken;
  time_fields_t expected_times [$];

  task automatic clear_parse();
    char_pos = '0;
    foreach (pairs[i]) pairs[i] = '0;
    zone_at = '0;
    zone = ZS_NONE;
    broken = 1'b0;
  endtask

  task automatic push_digit(input int idx, input int d);
    int v;
    v = pairs[idx] * 10 + d;
    pairs[idx] = v[6:0];
  endtask

  task automatic take_char(input logic [7:0] c, input logic is_last);
    int p, q, len, yy, year, mon, day, hr, mi, se, tzh, tzm, mlen, off;
    logic is_digit, ok, secs, nonutc, leap;
    time_fields_t res;
    p = char_pos;
    is_digit = c >= CH_ZERO && c <= CH_NINE;
    if (p >= POS_LIMIT) begin
      broken = 1'b1;
    end else if (zone == ZS_NONE) begin
      if (c == CH_UTC || c == CH_PLUS || c == CH_MINUS) begin
        zone_at = p[4:0];
        zone = (c == CH_UTC) ? ZS_UTC : ((c == CH_PLUS) ? ZS_PLUS : ZS_MINUS);
        if (p != POS_SHORT && p != POS_FULL) broken = 1'b1;
      end else if (!is_digit || p >= POS_FULL) begin
        broken = 1'b1;
      end else begin
        push_digit(p / 2, c - CH_ZERO);
      end
    end else begin
      q = p - int'(zone_at) - 1;
      if (zone == ZS_UTC || q >= OFS_CHARS || !is_digit) broken = 1'b1;
      else push_digit(IDX_OFS_HR + q / 2, c - CH_ZERO);
    end
    if (char_pos < POS_SAT) char_pos++;
    if (!is_last) return;

    len = p + 1;
    yy = pairs[IDX_YEAR];
    year = yy + ((yy >= YEAR_PIVOT) ? int'(CENTURY_19) : int'(CENTURY_20));
    mon = pairs[IDX_MONTH];
    day = pairs[IDX_DAY];
    hr = pairs[IDX_HOUR];
    mi = pairs[IDX_MINUTE];
    secs = zone_at == POS_FULL;
    se = secs ? int'(pairs[IDX_SECOND]) : 0;
    tzh = pairs[IDX_OFS_HR];
    tzm = pairs[IDX_OFS_MI];
    nonutc = zone == ZS_PLUS || zone == ZS_MINUS;
    leap = (year % 4 == 0) && ((year % 100 != 0) || (year % 400 == 0));
    case (mon)
      1, 3, 5, 7, 8, 10, 12: mlen = 31;
      4, 6, 9, 11:           mlen = 30;
      2:                     mlen = leap ? 29 : 28;
      default:               mlen = 0;
    endcase

    ok = !broken && zone != ZS_NONE &&
         (zone_at == POS_FULL || (zone_at == POS_SHORT && !der_on));
    if (mon < 1 || mon > 12 || day < 1 || day > mlen) ok = 1'b0;
    if (hr >= HOURS_PER_DAY || mi >= MINS_PER_HOUR || se >= MINS_PER_HOUR) ok = 1'b0;
    if (zone == ZS_UTC) begin
      if (len != int'(zone_at) + 1) ok = 1'b0;
    end else if (der_on || len != int'(zone_at) + OFS_CHARS + 1 ||
                 tzh >= HOURS_PER_DAY || tzm >= MINS_PER_HOUR) begin
      ok = 1'b0;
    end

    off = nonutc ? tzh * 60 + tzm : 0;
    if (zone == ZS_MINUS) off = -off;

    res = '0;
    if (ok) begin
      res.ok = 1'b1;
      res.year = year[11:0];
      res.month = mon[3:0];
      res.day = day[4:0];
      res.hour = hr[4:0];
      res.minute = mi[5:0];
      res.second = se[5:0];
      res.secs = secs;
      res.nonutc = nonutc;
      res.offset = off[11:0];
    end
    expected_times.push_back(res);
    clear_parse();
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      if (fail_count < 50)
        $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    time_fields_t want;
    if (!rst_n) begin
      der_on = 1'b0;
      clear_parse();
      expected_times.delete();
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (out_time_valid) valid_seen++;
        if (expected_times.size() == 0) begin
          if (fail_count < 50)
            $display("%0t: result word with nothing expected, expected none actual valid=%0b",
                     $time, out_time_valid);
          fail_count++;
        end else begin
          want = expected_times.pop_front();
          check_field("time_valid", want.ok, out_time_valid);
          check_field("full_year", want.year, out_full_year);
          check_field("month_num", want.month, out_month_num);
          check_field("day_num", want.day, out_day_num);
          check_field("hour_num", want.hour, out_hour_num);
          check_field("minute_num", want.minute, out_minute_num);
          check_field("second_num", want.second, out_second_num);
          check_field("seconds_present", want.secs, out_seconds_present);
          check_field("non_utc", want.nonutc, out_non_utc);
          check_field("offset_minutes", $signed(want.offset), out_offset_minutes);
        end
      end
      if (in_valid && in_ready) take_char(in_char_byte, in_last_char);
      if (cfg_wr_en) der_on = cfg_wr_data;
    end
    pending = expected_times.size();
  end

endmodule

FILE: tb/sv/utctime_string_validator_test.sv
`timescale 1ns / 1ps

module utctime_string_validator_test;
  import utcv_pkg::*;

  localparam int ITEM_TARGET = 2000;
  localparam int HOLD_OFF    = 4;
  localparam int SETTLE      = 10;
  localparam int IDLE_LIMIT  = 2000;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_wr_en = 1'b0;
  logic              cfg_wr_data = 1'b0;
  logic              in_valid = 1'b0;
  logic [7:0]        in_char_byte = '0;
  logic              in_last_char = 1'b0;
  logic              out_ready = 1'b0;
  logic              in_ready;
  logic              out_valid;
  logic              out_time_valid;
  logic [11:0]       out_full_year;
  logic [3:0]        out_month_num;
  logic [4:0]        out_day_num;
  logic [4:0]        out_hour_num;
  logic [5:0]        out_minute_num;
  logic [5:0]        out_second_num;
  logic              out_seconds_present;
  logic              out_non_utc;
  logic signed [11:0] out_offset_minutes;

  int fail_count, pending, results_seen, valid_seen;
  int chars_sent, strings_sent, burst_left, rx_run, idle_cycles, der_phases;
  bit rx_steady, der_now;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  utctime_string_validator dut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_char_byte(in_char_byte),
    .in_last_char(in_last_char),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_time_valid(out_time_valid),
    .out_full_year(out_full_year),
    .out_month_num(out_month_num),
    .out_day_num(out_day_num),
    .out_hour_num(out_hour_num),
    .out_minute_num(out_minute_num),
    .out_second_num(out_second_num),
    .out_seconds_present(out_seconds_present),
    .out_non_utc(out_non_utc),
    .out_offset_minutes(out_offset_minutes)
  );

  utctime_result_check result_check (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_char_byte(in_char_byte),
    .in_last_char(in_last_char),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_time_valid(out_time_valid),
    .out_full_year(out_full_year),
    .out_month_num(out_month_num),
    .out_day_num(out_day_num),
    .out_hour_num(out_hour_num),
    .out_minute_num(out_minute_num),
    .out_second_num(out_second_num),
    .out_seconds_present(out_seconds_present),
    .out_non_utc(out_non_utc),
    .out_offset_minutes(out_offset_minutes),
    .fail_count(fail_count),
    .pending(pending),
    .results_seen(results_seen),
    .valid_seen(valid_seen)
  );

  // receiver: runs of ready broken by random stalls
  always @(posedge clk) begin
    if (rx_run == 0) begin
      if (out_ready && !rx_steady && $urandom_range(0, 3) != 0) begin
        out_ready <= 1'b0;
        rx_run <= $urandom_range(1, 16);
      end else begin
        out_ready <= 1'b1;
        rx_run <= $urandom_range(1, 40);
      end
    end else begin
      rx_run <= rx_run - 1;
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no word moved for %0d cycles", $time, IDLE_LIMIT);
      $display("utctime_string_validator_test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic int pick(input int lo, input int hi);
    return ($urandom_range(0, 9) == 0) ? int'($urandom_range(0, 99)) : int'($urandom_range(lo, hi));
  endfunction

  function automatic logic [7:0] rand_char();
    case ($urandom_range(0, 7))
      0, 1, 2, 3: return 8'(CH_ZERO + $urandom_range(0, 9));
      4:          return CH_UTC;
      5:          return ($urandom_range(0, 1) == 1) ? CH_PLUS : CH_MINUS;
      default:    return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic void put_pair(ref logic [7:0] s[$], input int v);
    s.push_back(8'(CH_ZERO + v / 10));
    s.push_back(8'(CH_ZERO + v % 10));
  endfunction

  task automatic send_char(input logic [7:0] c, input logic is_last);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    in_valid <= 1'b1;
    in_char_byte <= c;
    in_last_char <= is_last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    burst_left--;
    chars_sent++;
  endtask

  task automatic send_string(input logic [7:0] s[$]);
    foreach (s[i]) send_char(s[i], i == s.size() - 1);
    strings_sent++;
  endtask

  task automatic send_text(input string t);
    logic [7:0] s[$];
    for (int i = 0; i < t.len(); i++) s.push_back(t[i]);
    send_string(s);
  endtask

  // hold the sender until every result is out, let the pipe settle, then write
  task automatic set_der(input bit v);
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
    repeat (HOLD_OFF) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    der_now = v;
    der_phases++;
  endtask

  task automatic send_random_string();
    logic [7:0] s[$];
    int kind, n, pos;
    bit with_secs;
    kind = $urandom_range(0, 9);
    if (kind <= 6) begin
      put_pair(s, $urandom_range(0, 99));
      put_pair(s, pick(1, 12));
      put_pair(s, pick(1, 31));
      put_pair(s, pick(0, 23));
      put_pair(s, pick(0, 59));
      with_secs = der_now ? ($urandom_range(0, 7) != 0) : $urandom_range(0, 1);
      if (with_secs) put_pair(s, pick(0, 59));
      case ($urandom_range(0, der_now ? 7 : 3))
        0: begin
          s.push_back(CH_PLUS);
          put_pair(s, pick(0, 23));
          put_pair(s, pick(0, 59));
        end
        1: begin
          s.push_back(CH_MINUS);
          put_pair(s, pick(0, 23));
          put_pair(s, pick(0, 59));
        end
        default: s.push_back(CH_UTC);
      endcase
      if (kind == 6) begin
        pos = $urandom_range(0, s.size() - 1);
        case ($urandom_range(0, 2))
          0:       s[pos] = 8'($urandom_range(0, 255));
          1:       s = s[0:pos];
          default: repeat ($urandom_range(1, 3)) s.push_back(rand_char());
        endcase
      end
    end else begin
      n = (kind == 9) ? $urandom_range(16, 34) : $urandom_range(1, 16);
      repeat (n) s.push_back(rand_char());
    end
    send_string(s);
  endtask

  initial begin
    logic [7:0] s[$];
    int n;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    set_der(1'b0);
    send_text("491231235959Z");
    send_text("500101000000Z");
    send_text("0002291200Z");
    send_text("9902291200Z");
    send_text("2406151230+2359");
    send_text("240615123045-2359");
    send_text("240615123045+2400");
    send_text("240615123045-1260");
    send_text("2406151230Z1");
    send_text("24061512304Z");
    send_text("24A615123045Z");
    send_text("240615123045+12a0");
    send_text("240615123045+123");
    send_text("240615123045-00001");
    send_text("241301000000Z");
    send_text("240431000000Z");
    send_text("240615240000Z");
    send_text("240615236000Z");
    send_text("240615235960Z");
    send_text("Z");
    s = {8'hFF};
    send_string(s);
    s = {8'h00, 8'h80, CH_UTC};
    send_string(s);
    s.delete();
    repeat (35) s.push_back(8'h31);
    send_string(s);

    set_der(1'b1);
    send_text("240615123045Z");
    send_text("2406151230Z");
    send_text("240615123045+0100");

    while (chars_sent < ITEM_TARGET) begin
      set_der($urandom_range(0, 1));
      rx_steady = ($urandom_range(0, 3) == 0);
      n = $urandom_range(5, 30);
      repeat (n) send_random_string();
    end

    rx_steady = 1'b0;
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (SETTLE) @(posedge clk);

    $display("%0d strings (%0d characters) over %0d DER settings; %0d results checked, %0d valid",
             strings_sent, chars_sent, der_phases, results_seen, valid_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("utctime_string_validator_test passed");
    end else begin
      $display("utctime_string_validator_test failed");
    end
    $finish;
  end

endmodule

FILE: files.f
design/utcv_pkg.sv
design/utcv_front.sv
design/utcv_queue.sv
design/utcv_back.sv
design/utctime_string_validator.sv
tb/sv/utctime_result_check.sv
tb/sv/utctime_string_validator_test.sv
